// ===== design/ansi_csi_console_parser_defines.svh =====
// ----------------------------------------------------------------------------
// ansi_csi_console_parser_defines.svh
// Assertion macros shared by the console parser RTL.
// ----------------------------------------------------------------------------
`ifndef ANSI_CSI_CONSOLE_PARSER_DEFINES_SVH
`define ANSI_CSI_CONSOLE_PARSER_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define ACP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked on every clock edge outside reset
`define ACP_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// ===== design/acp_pkg.sv =====
// ----------------------------------------------------------------------------
// acp_pkg
// Types, codes and helper functions of the ANSI CSI console parser.
// ----------------------------------------------------------------------------
`default_nettype none

package acp_pkg;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_ED    = 8'h4A;  // 'J'
  localparam logic [7:0] CH_CUP_H = 8'h48;  // 'H'
  localparam logic [7:0] CH_CUP_F = 8'h66;  // 'f'
  localparam logic [7:0] CH_SGR   = 8'h6D;  // 'm'
  localparam logic [7:0] CH_FIN_LO = 8'h40;
  localparam logic [7:0] CH_FIN_HI = 8'h7E;

  localparam logic [3:0] FORE_DEFAULT = 4'd7;
  localparam logic [3:0] BACK_DEFAULT = 4'd0;
  localparam logic [15:0] NUM_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_COLOR  = 3'd3,
    CMD_FLUSH  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PS_IDLE = 2'd0,
    PS_ESC  = 2'd1,
    PS_COLL = 2'd2
  } parse_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESC_PUT,
    ST_PUT,
    ST_WALK,
    ST_FIN,
    ST_EXEC,
    ST_FLUSH
  } seq_e;

  typedef enum logic [1:0] {
    RUN_CLEAR,
    RUN_CUP,
    RUN_SGR
  } run_e;

  // Control of the shared number accumulator
  typedef struct packed {
    logic clr;
    logic step;
  } acc_ctrl_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic mirrors(input logic [7:0] c);
    return (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09) ||
           ((c >= 8'h20) && (c < 8'h7F));
  endfunction

  // ANSI colour order to VGA colour order
  function automatic logic [2:0] color_map(input logic [2:0] a);
    logic [2:0] r;
    unique case (a)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      3'd7: r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/acp_param_ram.sv =====
// ----------------------------------------------------------------------------
// acp_param_ram
// Parameter character store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module acp_param_ram #(
  parameter int Depth = 32,
  parameter int Aw    = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [Aw-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/acp_num_acc.sv =====
// ----------------------------------------------------------------------------
// acp_num_acc
// Shared decimal accumulator: value * 10 + digit, saturating at 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module acp_num_acc
  import acp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire acc_ctrl_t ctrl_i,
  input  wire logic [3:0] digit_i,
  output logic     [15:0] value_o
);

  logic [15:0] acc_q, acc_d;
  logic [19:0] sum;

  // x10 as two shifts plus the digit
  assign sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, digit_i};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.step) begin
      acc_d = (sum > {4'd0, NUM_MAX}) ? NUM_MAX : sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign value_o = acc_q;

endmodule

`default_nettype wire

// ===== design/ansi_csi_console_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_csi_console_parser
// Console byte parser for a VGA text console with an ANSI CSI subset.
// ----------------------------------------------------------------------------
// One byte is taken per transfer while the sequencer is idle. Plain bytes and
// collected parameter characters give at most three results (escape echo,
// character, flush). A CUP or SGR final walks the stored parameter characters
// through the registered store read port and the shared decimal accumulator,
// one character per cycle, then passes through the finish and execute states;
// a flush follows at the end of a write, and both can wait on the output
// register. The output register lets the next byte be taken while a result
// still waits for its transfer.
`default_nettype none

module ansi_csi_console_parser
  import acp_pkg::*;
#(
  parameter int PARAM_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_write_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       command_o,
  output logic [7:0]       char_code_o,
  output logic             mirror_serial_o,
  output logic [15:0]      cursor_row_o,
  output logic [15:0]      cursor_col_o,
  output logic [3:0]       fore_color_o,
  output logic [3:0]       back_color_o,
  output logic             last_o
);

`include "ansi_csi_console_parser_defines.svh"

  localparam int Aw = $clog2(PARAM_DEPTH);
  localparam logic [Aw-1:0] StoreMax = Aw'(PARAM_DEPTH - 1);

  seq_e          state_q, state_d;
  parse_e        ps_q, ps_d;
  run_e          run_q, run_d;
  logic [Aw-1:0] count_q, count_d;
  logic [Aw-1:0] lim_q, lim_d;
  logic [Aw-1:0] rd_idx_q, rd_idx_d;
  logic          pend_q, pend_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    byte_q, byte_d;
  logic          eow_q, eow_d;
  logic [1:0]    phase_q, phase_d;
  logic          has_q, has_d;
  logic          bold_q, bold_d;
  logic [3:0]    fore_q, fore_d;
  logic [3:0]    back_q, back_d;
  logic [15:0]   row_q, row_d;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_cmd_q, out_cmd_d;
  logic [7:0]    out_ch_q, out_ch_d;
  logic          out_mir_q, out_mir_d;
  logic [15:0]   out_row_q, out_row_d;
  logic [15:0]   out_col_q, out_col_d;
  logic [3:0]    out_fg_q, out_fg_d;
  logic [3:0]    out_bg_q, out_bg_d;
  logic          out_last_q, out_last_d;

  logic          in_xfer, out_free;
  logic          ram_we;
  logic [7:0]    rdata;
  acc_ctrl_t     acc_ctrl;
  logic [15:0]   acc_val;
  logic          walk_done;
  logic          is_param, is_final, can_store;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign walk_done  = !pend_q && (rd_idx_q == lim_q);

  assign is_param  = is_digit(data_byte_i) || (data_byte_i == CH_SEMI) ||
                     (data_byte_i == CH_SPACE) || (data_byte_i == CH_QUERY);
  assign is_final  = (data_byte_i >= CH_FIN_LO) && (data_byte_i <= CH_FIN_HI);
  assign can_store = (count_q < StoreMax);
  assign ram_we    = in_xfer && (ps_q == PS_COLL) && (is_param || is_final) && can_store;

  acp_param_ram #(
    .Depth(PARAM_DEPTH),
    .Aw   (Aw)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q),
    .wdata_i(data_byte_i),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  acp_num_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .digit_i(rdata[3:0]),
    .value_o(acc_val)
  );

  // Decision on a CSI final byte taken in the collecting state
  function automatic logic [1:0] final_kind(input logic [7:0] c, input logic [7:0] first,
                                            input logic no_par);
    // 0 nothing, 1 clear, 2 cursor, 3 colour
    logic [1:0] k;
    k = 2'd0;
    if (!no_par && (first == CH_QUERY)) begin
      k = 2'd0;
    end else if (c == CH_ED) begin
      if (no_par || (first == 8'h32) || (first == 8'h33)) k = 2'd1;
    end else if ((c == CH_CUP_H) || (c == CH_CUP_F)) begin
      k = 2'd2;
    end else if (c == CH_SGR) begin
      k = 2'd3;
    end
    return k;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (ps_q == PS_ESC) begin
            if (data_byte_i == CH_LBR) state_d = end_of_write_i ? ST_FLUSH : ST_IDLE;
            else                       state_d = ST_ESC_PUT;
          end else if (ps_q == PS_COLL) begin
            if (is_final && can_store &&
                (final_kind(data_byte_i, first_q, count_q == '0) == 2'd1)) begin
              state_d = ST_EXEC;
            end else if (is_final && can_store &&
                         (final_kind(data_byte_i, first_q, count_q == '0) != 2'd0)) begin
              state_d = ST_WALK;
            end else begin
              state_d = end_of_write_i ? ST_FLUSH : ST_IDLE;
            end
          end else begin
            if (data_byte_i == CH_ESC) state_d = end_of_write_i ? ST_FLUSH : ST_IDLE;
            else                       state_d = ST_PUT;
          end
        end
      end
      ST_ESC_PUT: if (out_free) state_d = ST_PUT;
      ST_PUT:     if (out_free) state_d = eow_q ? ST_FLUSH : ST_IDLE;
      ST_WALK:    if (walk_done) state_d = ST_FIN;
      ST_FIN:     state_d = ST_EXEC;
      ST_EXEC:    if (out_free) state_d = eow_q ? ST_FLUSH : ST_IDLE;
      ST_FLUSH:   if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and result loading
  always_comb begin
    logic [1:0]  kind;
    logic [15:0] num;
    logic        apply;
    logic [15:0] fin_row;

    ps_d     = ps_q;
    run_d    = run_q;
    count_d  = count_q;
    lim_d    = lim_q;
    rd_idx_d = rd_idx_q;
    pend_d   = 1'b0;
    first_d  = first_q;
    byte_d   = byte_q;
    eow_d    = eow_q;
    phase_d  = phase_q;
    has_d    = has_q;
    bold_d   = bold_q;
    fore_d   = fore_q;
    back_d   = back_q;
    row_d    = row_q;
    acc_ctrl = '0;
    kind     = 2'd0;
    num      = acc_val;
    apply    = 1'b0;
    fin_row  = (phase_q == 2'd0) ? acc_val : row_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_cmd_d   = out_cmd_q;
    out_ch_d    = out_ch_q;
    out_mir_d   = out_mir_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_fg_d    = out_fg_q;
    out_bg_d    = out_bg_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          byte_d = data_byte_i;
          eow_d  = end_of_write_i;
          unique case (ps_q)
            PS_ESC: begin
              if (data_byte_i == CH_LBR) begin
                ps_d    = PS_COLL;
                count_d = '0;
              end else begin
                ps_d = PS_IDLE;
              end
            end
            PS_COLL: begin
              if (is_param) begin
                if (can_store) begin
                  count_d = count_q + 1'b1;
                  if (count_q == '0) first_d = data_byte_i;
                end
              end else begin
                kind = final_kind(data_byte_i, first_q, count_q == '0);
                ps_d    = PS_IDLE;
                count_d = '0;
                lim_d   = count_q;
                unique case (kind)
                  2'd2:    run_d = RUN_CUP;
                  2'd3:    run_d = RUN_SGR;
                  default: run_d = RUN_CLEAR;
                endcase
                rd_idx_d = '0;
                phase_d  = 2'd0;
                has_d    = 1'b0;
                bold_d   = 1'b0;
                acc_ctrl.clr = 1'b1;
              end
            end
            default: begin
              ps_d = (data_byte_i == CH_ESC) ? PS_ESC : PS_IDLE;
            end
          endcase
        end
      end

      ST_WALK: begin
        // issue the next read while processing the previous one
        if (rd_idx_q != lim_q) begin
          rd_idx_d = rd_idx_q + 1'b1;
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          if (run_q == RUN_CUP) begin
            unique case (phase_q)
              2'd0: begin
                if (is_digit(rdata)) begin
                  acc_ctrl.step = 1'b1;
                end else begin
                  row_d        = acc_val;
                  acc_ctrl.clr = 1'b1;
                  phase_d      = (rdata == CH_SEMI) ? 2'd1 : 2'd2;
                end
              end
              2'd1: begin
                if (is_digit(rdata)) acc_ctrl.step = 1'b1;
                else                 phase_d = 2'd2;
              end
              default: ;
            endcase
          end else begin
            if (is_digit(rdata)) begin
              acc_ctrl.step = 1'b1;
              has_d         = 1'b1;
            end else begin
              apply        = has_q;
              has_d        = 1'b0;
              acc_ctrl.clr = 1'b1;
            end
          end
        end
      end

      ST_FIN: begin
        if (run_q == RUN_SGR) begin
          if (lim_q == '0) begin
            fore_d = FORE_DEFAULT;
            back_d = BACK_DEFAULT;
          end else begin
            apply = has_q;
          end
        end else begin
          row_d = fin_row;
          phase_d = 2'd1;
          // column stays in the accumulator
          if (phase_q == 2'd0) acc_ctrl.clr = 1'b1;
        end
      end

      ST_ESC_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cmd_d   = CMD_PUT;
          out_ch_d    = CH_ESC;
          out_mir_d   = 1'b1;
          out_row_d   = '0;
          out_col_d   = '0;
          out_fg_d    = '0;
          out_bg_d    = '0;
          out_last_d  = 1'b0;
        end
      end

      ST_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cmd_d   = CMD_PUT;
          out_ch_d    = byte_q;
          out_mir_d   = mirrors(byte_q);
          out_row_d   = '0;
          out_col_d   = '0;
          out_fg_d    = '0;
          out_bg_d    = '0;
          out_last_d  = !eow_q;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ch_d    = '0;
          out_mir_d   = 1'b0;
          out_row_d   = '0;
          out_col_d   = '0;
          out_fg_d    = '0;
          out_bg_d    = '0;
          out_last_d  = !eow_q;
          unique case (run_q)
            RUN_CUP: begin
              out_cmd_d = CMD_CURSOR;
              out_row_d = (row_q == '0) ? 16'd0 : row_q - 16'd1;
              out_col_d = (acc_val == '0) ? 16'd0 : acc_val - 16'd1;
            end
            RUN_SGR: begin
              out_cmd_d = CMD_COLOR;
              out_fg_d  = fore_q;
              out_bg_d  = back_q;
            end
            default: out_cmd_d = CMD_CLEAR;
          endcase
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cmd_d   = CMD_FLUSH;
          out_ch_d    = '0;
          out_mir_d   = 1'b0;
          out_row_d   = '0;
          out_col_d   = '0;
          out_fg_d    = '0;
          out_bg_d    = '0;
          out_last_d  = 1'b1;
        end
      end

      default: ;
    endcase

    // SGR number takes effect
    if (apply) begin
      priority if (num == 16'd0) begin
        fore_d = FORE_DEFAULT;
        back_d = BACK_DEFAULT;
        bold_d = 1'b0;
      end else if (num == 16'd1) begin
        bold_d = 1'b1;
      end else if ((num >= 16'd30) && (num <= 16'd37)) begin
        fore_d = {bold_q, color_map(num[2:0] - 3'd6)};
      end else if ((num >= 16'd40) && (num <= 16'd47)) begin
        back_d = {1'b0, color_map(num[2:0])};
      end else if ((num >= 16'd90) && (num <= 16'd97)) begin
        fore_d = {1'b1, color_map(num[2:0] - 3'd2)};
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ps_q        <= PS_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      fore_q      <= FORE_DEFAULT;
      back_q      <= BACK_DEFAULT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ps_q        <= ps_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      fore_q      <= fore_d;
      back_q      <= back_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    lim_q      <= lim_d;
    rd_idx_q   <= rd_idx_d;
    first_q    <= first_d;
    byte_q     <= byte_d;
    eow_q      <= eow_d;
    phase_q    <= phase_d;
    has_q      <= has_d;
    bold_q     <= bold_d;
    row_q      <= row_d;
    out_cmd_q  <= out_cmd_d;
    out_ch_q   <= out_ch_d;
    out_mir_q  <= out_mir_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_fg_q   <= out_fg_d;
    out_bg_q   <= out_bg_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign command_o       = out_cmd_q;
  assign char_code_o     = out_ch_q;
  assign mirror_serial_o = out_mir_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_col_o    = out_col_q;
  assign fore_color_o    = out_fg_q;
  assign back_color_o    = out_bg_q;
  assign last_o          = out_last_q;

  // checks
  `ACP_ASSERT_IMP(a_flush_last, out_valid_o && (command_o == CMD_FLUSH), last_o, "flush not last")
  `ACP_ASSERT_IMP(a_walk_bound, state_q == ST_WALK, rd_idx_q <= lim_q, "walk overran store")
  `ACP_ASSERT_ALW(a_count_bound, count_q <= StoreMax, "parameter count overflow")

endmodule

`default_nettype wire
